>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros for cdq_dpath; expect clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CDQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed (same cycle)");

// next-cycle implication
`define CDQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed (next cycle)");

`endif

>>> sv/cdq_pkg.sv
// ---------------------------------------------------------------------------
// cdq_pkg
// Opcodes, error codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package cdq_pkg;

  localparam logic [1:0] OP_PUSH_REAR  = 2'd0;
  localparam logic [1:0] OP_PUSH_FRONT = 2'd1;
  localparam logic [1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [1:0] OP_POP_REAR   = 2'd3;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_FULL  = 2'd1;
  localparam logic [1:0] ERR_EMPTY = 2'd2;

  // read address select
  typedef logic [1:0] rd_sel_t;
  localparam rd_sel_t RD_POP   = 2'd0;
  localparam rd_sel_t RD_FRONT = 2'd1;
  localparam rd_sel_t RD_REAR  = 2'd2;

  localparam int CNT_W = 7;

  typedef struct packed {
    logic    latch;
    logic    exec;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    cap_pop;
    logic    cap_front;
    logic    load_out;
  } cdq_cmd_t;

  typedef struct packed {
    logic out_busy;
  } cdq_stat_t;

endpackage

>>> sv/cdq_ctrl.sv
// ---------------------------------------------------------------------------
// cdq_ctrl
// Sequencer: accept, execute, read front/rear slots, write back result.
// ---------------------------------------------------------------------------
module cdq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cdq_pkg::cdq_stat_t stat_i,
  output cdq_pkg::cdq_cmd_t  cmd_o
);
  import cdq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RDF  = 3'd2;
  localparam logic [2:0] S_RDR  = 3'd3;
  localparam logic [2:0] S_WB   = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd_o.latch = in_valid;
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec   = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_POP;
        state_nxt    = S_RDF;
      end
      S_RDF: begin
        cmd_o.cap_pop = 1'b1;
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = RD_FRONT;
        state_nxt     = S_RDR;
      end
      S_RDR: begin
        cmd_o.cap_front = 1'b1;
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_sel    = RD_REAR;
        state_nxt       = S_WB;
      end
      S_WB: begin
        // wait for the output word to drain
        if (!stat_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/cdq_dpath.sv
// ---------------------------------------------------------------------------
// cdq_dpath
// Slot memory, front/rear pointers, status and output word register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cdq_dpath #(
  parameter int DEPTH = 128
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [1:0]             in_opcode,
  input  logic [7:0]             in_value,
  input  cdq_pkg::cdq_cmd_t      cmd_i,
  output cdq_pkg::cdq_stat_t     stat_o,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_popped_value,
  output logic [1:0]             out_error_code,
  output logic [cdq_pkg::CNT_W-1:0] out_entry_count,
  output logic                   out_is_empty_flag,
  output logic                   out_is_full_flag,
  output logic [7:0]             out_front_byte,
  output logic [7:0]             out_rear_byte
);
  import cdq_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = IW + 1;
  localparam logic [IW-1:0] LAST  = IW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] p);
    return (p == '0) ? LAST : p - 1'b1;
  endfunction

  logic [7:0]    mem [DEPTH];
  logic [1:0]    op_r;
  logic [7:0]    val_r;
  logic [IW-1:0] front_r, front_nxt;
  logic [IW-1:0] rear_r, rear_nxt;
  logic [1:0]    err_r, err_nxt;
  logic [7:0]    pop_r;
  logic [7:0]    frontb_r;
  logic [7:0]    rdata_r;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [IW-1:0] rd_addr;
  logic          empty_now, full_now;
  logic [CW-1:0] cnt;
  logic [CW+CNT_W-1:0] cnt_ext;
  logic          out_valid_r;

  assign empty_now = (front_r == rear_r);
  assign full_now  = (wrap_inc(rear_r) == front_r);

  always_comb begin
    front_nxt = front_r;
    rear_nxt  = rear_r;
    err_nxt   = ERR_OK;
    wr_en     = 1'b0;
    wr_addr   = wrap_inc(rear_r);
    case (op_r)
      OP_PUSH_REAR: begin
        if (full_now) begin
          err_nxt = ERR_FULL;
        end else begin
          wr_en    = cmd_i.exec;
          wr_addr  = wrap_inc(rear_r);
          rear_nxt = wrap_inc(rear_r);
        end
      end
      OP_PUSH_FRONT: begin
        if (full_now) begin
          err_nxt = ERR_FULL;
        end else begin
          wr_en     = cmd_i.exec;
          wr_addr   = front_r;
          front_nxt = wrap_dec(front_r);
        end
      end
      OP_POP_FRONT: begin
        if (empty_now) err_nxt = ERR_EMPTY;
        else front_nxt = wrap_inc(front_r);
      end
      default: begin
        if (empty_now) err_nxt = ERR_EMPTY;
        else rear_nxt = wrap_dec(rear_r);
      end
    endcase
  end

  // pop reads use the pointers before they move
  always_comb begin
    case (cmd_i.rd_sel)
      RD_POP:   rd_addr = (op_r == OP_POP_FRONT) ? wrap_inc(front_r) : rear_r;
      RD_FRONT: rd_addr = wrap_inc(front_r);
      default:  rd_addr = rear_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= val_r;
    if (cmd_i.rd_en) rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd_i.latch) begin
      op_r  <= in_opcode;
      val_r <= in_value;
    end
    if (cmd_i.exec) err_r <= err_nxt;
    if (cmd_i.cap_pop) begin
      pop_r <= ((err_r == ERR_OK) && op_r[1]) ? rdata_r : 8'd0;
    end
    if (cmd_i.cap_front) frontb_r <= rdata_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      rear_r  <= '0;
    end else if (cmd_i.exec) begin
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
    end
  end

  assign cnt     = (rear_r >= front_r) ? (CW'(rear_r) - CW'(front_r))
                                       : (CW'(rear_r) + DEPTH_C - CW'(front_r));
  assign cnt_ext = {{CNT_W{1'b0}}, cnt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load_out) begin
      out_popped_value  <= pop_r;
      out_error_code    <= err_r;
      out_entry_count   <= cnt_ext[CNT_W-1:0];
      out_is_empty_flag <= empty_now;
      out_is_full_flag  <= full_now;
      out_front_byte    <= empty_now ? 8'd0 : frontb_r;
      out_rear_byte     <= empty_now ? 8'd0 : rdata_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign stat_o.out_busy = out_valid_r && !out_ready;

  `CDQ_ASSERT_NOW(a_ptr_range, 1'b1, (front_r <= LAST) && (rear_r <= LAST))
  `CDQ_ASSERT_NEXT(a_err_holds_ptrs, cmd_i.exec && (err_nxt != ERR_OK),
                   (front_r == $past(front_r)) && (rear_r == $past(rear_r)))
  `CDQ_ASSERT_NOW(a_no_overwrite, cmd_i.load_out, !out_valid_r || out_ready)

endmodule

>>> sv/circular_deque_top.sv
// ---------------------------------------------------------------------------
// circular_deque_top
// Byte deque in a circular slot memory; one status word per operation.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries an opcode and a byte: push rear,
//   push front, pop front, pop rear. Each accepted word yields exactly one
//   result word on out_valid/out_ready: popped byte, error code, count,
//   empty/full flags and the front and rear bytes after the operation.
//   Capacity is DEPTH-1 bytes. A push when full or pop when empty reports an
//   error and leaves the deque unchanged.
//   An accepted word passes through execute, front read, rear read and
//   write-back before out_valid rises. One word is worked on at a time; the
//   single-read-port slot memory is visited three times per word (popped slot,
//   front slot, rear slot), so a new word is taken only after write-back.
//   The result sits in an output register, so the next word is accepted
//   while it waits; if the receiver still stalls when the following result
//   is ready, the block holds in write-back until the register frees.
//   Reset (rst_n low, synchronous) empties the deque and clears out_valid;
//   slot contents are not cleared.
// ---------------------------------------------------------------------------
module circular_deque_top #(
  parameter int DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_popped_value,
  output logic [1:0] out_error_code,
  output logic [cdq_pkg::CNT_W-1:0] out_entry_count,
  output logic       out_is_empty_flag,
  output logic       out_is_full_flag,
  output logic [7:0] out_front_byte,
  output logic [7:0] out_rear_byte
);
  import cdq_pkg::*;

  cdq_cmd_t  cmd;
  cdq_stat_t stat;

  cdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  cdq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_opcode         (in_opcode),
    .in_value          (in_value),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_popped_value  (out_popped_value),
    .out_error_code    (out_error_code),
    .out_entry_count   (out_entry_count),
    .out_is_empty_flag (out_is_empty_flag),
    .out_is_full_flag  (out_is_full_flag),
    .out_front_byte    (out_front_byte),
    .out_rear_byte     (out_rear_byte)
  );

endmodule

>>> verif/circular_deque_checker.sv
// ----------------------------------------------------------------------------
// circular_deque_checker
// Watches both channels of the deque, keeps its own copy of the slot store and
// the two indexes, works out the status word due for every accepted operation
// and compares each returned word against the oldest one outstanding.
// ----------------------------------------------------------------------------
module circular_deque_checker #(
  parameter int DEPTH = 128
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [1:0]                in_opcode,
  input  logic [7:0]                in_value,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [7:0]                out_popped_value,
  input  logic [1:0]                out_error_code,
  input  logic [cdq_pkg::CNT_W-1:0] out_entry_count,
  input  logic                      out_is_empty_flag,
  input  logic                      out_is_full_flag,
  input  logic [7:0]                out_front_byte,
  input  logic [7:0]                out_rear_byte,
  output int                        fail_count,
  output int                        pending,
  output int                        words_checked,
  output int                        full_rejects,
  output int                        empty_rejects,
  output int                        full_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  import cdq_pkg::*;

  localparam int REPORT_CAP = 40;

  typedef struct packed {
    logic [7:0]       popped;
    logic [1:0]       err;
    logic [CNT_W-1:0] count;
    logic             empty;
    logic             full;
    logic [7:0]       front;
    logic [7:0]       rear;
  } deque_status_t;

  logic [7:0]    slots [DEPTH];
  int unsigned   head_ix;  // empty slot just ahead of the first byte
  int unsigned   tail_ix;  // last byte
  deque_status_t due_status [$];

  int fails, checked, n_full_rej, n_empty_rej, n_full;

  function automatic int unsigned step_up(int unsigned i);
    return (i + 1) % DEPTH;
  endfunction

  function automatic int unsigned step_down(int unsigned i);
    return (i + DEPTH - 1) % DEPTH;
  endfunction

  function automatic logic held_none();
    return head_ix == tail_ix;
  endfunction

  function automatic logic held_max();
    return step_up(tail_ix) == head_ix;
  endfunction

  // apply one operation to the shadow deque and return the status it yields
  function automatic deque_status_t apply_op(logic [1:0] op, logic [7:0] val);
    deque_status_t r;
    int unsigned   held;
    r = '0;
    case (op)
      OP_PUSH_REAR: begin
        if (held_max()) begin
          r.err = ERR_FULL;
        end else begin
          tail_ix = step_up(tail_ix);
          slots[tail_ix] = val;
        end
      end
      OP_PUSH_FRONT: begin
        if (held_max()) begin
          r.err = ERR_FULL;
        end else begin
          slots[head_ix] = val;
          head_ix = step_down(head_ix);
        end
      end
      OP_POP_FRONT: begin
        if (held_none()) begin
          r.err = ERR_EMPTY;
        end else begin
          head_ix = step_up(head_ix);
          r.popped = slots[head_ix];
        end
      end
      default: begin
        if (held_none()) begin
          r.err = ERR_EMPTY;
        end else begin
          r.popped = slots[tail_ix];
          tail_ix = step_down(tail_ix);
        end
      end
    endcase
    held = (tail_ix + DEPTH - head_ix) % DEPTH;
    r.count = held[CNT_W-1:0];
    r.empty = held_none();
    r.full  = held_max();
    if (!r.empty) begin
      r.front = slots[step_up(head_ix)];
      r.rear  = slots[tail_ix];
    end
    return r;
  endfunction

  function automatic void note_field(string field, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      fails++;
      if (fails <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endfunction

  always @(posedge clk) begin
    deque_status_t want;
    if (!rst_n) begin
      head_ix = 0;
      tail_ix = 0;
      due_status.delete();
      fails       = 0;
      checked     = 0;
      n_full_rej  = 0;
      n_empty_rej = 0;
      n_full      = 0;
    end else begin
      if (in_valid && in_ready) begin
        want = apply_op(in_opcode, in_value);
        if (want.err == ERR_FULL) n_full_rej++;
        if (want.err == ERR_EMPTY) n_empty_rej++;
        if (want.full) n_full++;
        due_status.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (due_status.size() == 0) begin
          fails++;
          $display("%0t: status word arrived with nothing outstanding", $time);
        end else begin
          want = due_status.pop_front();
          checked++;
          note_field("popped_value", want.popped, out_popped_value);
          note_field("error_code", 8'(want.err), 8'(out_error_code));
          note_field("entry_count", 8'(want.count), 8'(out_entry_count));
          note_field("is_empty_flag", 8'(want.empty), 8'(out_is_empty_flag));
          note_field("is_full_flag", 8'(want.full), 8'(out_is_full_flag));
          note_field("front_byte", want.front, out_front_byte);
          note_field("rear_byte", want.rear, out_rear_byte);
        end
      end
    end
    pending       <= due_status.size();
    fail_count    <= fails;
    words_checked <= checked;
    full_rejects  <= n_full_rej;
    empty_rejects <= n_empty_rej;
    full_seen     <= n_full;
  end

endmodule

>>> verif/circular_deque_top_test.sv
// ----------------------------------------------------------------------------
// circular_deque_top_test
// Drives push/pop words into the deque: a short directed opening, then random
// phases biased to fill, drain or mix so both the full and the empty limits
// are hit many times over, with random input idling and output back-pressure.
// ----------------------------------------------------------------------------
module circular_deque_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cdq_pkg::*;

  localparam int DEPTH       = 128;
  localparam int ITEMS       = 1750;
  localparam int QUIET_FROM  = ITEMS - 200;  // no idling past here
  localparam int STUCK_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_BOTH} mix_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_opcode = OP_PUSH_REAR;
  logic [7:0] in_value = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b1;
  logic [7:0] out_popped_value;
  logic [1:0] out_error_code;
  logic [CNT_W-1:0] out_entry_count;
  logic       out_is_empty_flag;
  logic       out_is_full_flag;
  logic [7:0] out_front_byte;
  logic [7:0] out_rear_byte;

  int fail_count, pending, words_checked, full_rejects, empty_rejects, full_seen;

  int   n_sent = 0;
  int   stall_left = 0;
  int   stuck_cycles = 0;
  logic tx_idle_on = 1'b0;
  logic rx_idle_on = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  circular_deque_top #(.DEPTH(DEPTH)) dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_opcode, .in_value,
    .out_valid, .out_ready, .out_popped_value, .out_error_code, .out_entry_count,
    .out_is_empty_flag, .out_is_full_flag, .out_front_byte, .out_rear_byte
  );

  circular_deque_checker #(.DEPTH(DEPTH)) chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_opcode, .in_value,
    .out_valid, .out_ready, .out_popped_value, .out_error_code, .out_entry_count,
    .out_is_empty_flag, .out_is_full_flag, .out_front_byte, .out_rear_byte,
    .fail_count, .pending, .words_checked, .full_rejects, .empty_rejects, .full_seen
  );

  // receiver stalls in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 7);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, STUCK_LIMIT);
      $display("circular_deque_top_test: done, errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_word(logic [1:0] op, logic [7:0] val);
    if (tx_idle_on && n_sent < QUIET_FROM && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_value  <= val;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [1:0] pick_op(int push_pct);
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
    return $urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT;
  endfunction

  initial begin
    mix_t mix;
    int   phase_no;
    int   phase_len;
    int   push_pct;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // opening: empty pops, both pushes at the byte extremes, pops from both ends
    send_word(OP_POP_FRONT, 8'hFF);
    send_word(OP_POP_REAR, 8'h00);
    send_word(OP_PUSH_REAR, 8'h00);
    send_word(OP_PUSH_FRONT, 8'hFF);
    send_word(OP_PUSH_REAR, 8'h5A);
    send_word(OP_PUSH_FRONT, 8'hA5);
    send_word(OP_POP_FRONT, 8'h00);
    send_word(OP_POP_REAR, 8'hFF);
    send_word(OP_POP_REAR, 8'h00);
    send_word(OP_POP_FRONT, 8'h00);
    send_word(OP_POP_REAR, 8'h3C);
    send_word(OP_PUSH_FRONT, 8'h80);
    send_word(OP_POP_REAR, 8'h00);
    send_word(OP_PUSH_REAR, 8'h7F);
    send_word(OP_POP_FRONT, 8'hC3);
    send_word(OP_POP_FRONT, 8'h00);
    send_word(OP_PUSH_REAR, 8'h01);
    send_word(OP_PUSH_FRONT, 8'hFE);
    hold_until_drained();

    phase_no = 0;
    while (n_sent < ITEMS) begin
      // open with a fill to the top and a drain to the bottom, then anything
      if (phase_no == 0)
        mix = MIX_FILL;
      else if (phase_no == 1)
        mix = MIX_DRAIN;
      else
        mix = mix_t'($urandom_range(0, 2));
      case (mix)
        MIX_FILL:  push_pct = 90;
        MIX_DRAIN: push_pct = 10;
        default:   push_pct = 50;
      endcase
      phase_len  = (phase_no < 2) ? 240 : $urandom_range(60, 280);
      tx_idle_on = $urandom_range(0, 3) != 0;
      rx_idle_on <= (n_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
      for (int k = 0; k < phase_len && n_sent < ITEMS; k++) begin
        if (n_sent == QUIET_FROM) rx_idle_on <= 1'b0;
        send_word(pick_op(push_pct), pick_byte());
      end
      if (phase_no == 3) hold_until_drained();
      phase_no++;
    end

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d operations sent, %0d status words checked", n_sent, words_checked);
    $display("deque full after %0d operations; %0d pushes refused, %0d pops refused",
             full_seen, full_rejects, empty_rejects);
    if (fail_count == 0 && pending == 0) begin
      $display("circular_deque_top_test: done, clean");
    end else begin
      $display("circular_deque_top_test: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/cdq_pkg.sv
sv/cdq_ctrl.sv
sv/cdq_dpath.sv
sv/circular_deque_top.sv
verif/circular_deque_checker.sv
verif/circular_deque_top_test.sv
